// ===== sv/cvf_pkg.sv =====
// ----------------------------------------------------------------------------
// cvf_pkg: shared types and constants of the cosine volume fade block
// Holds the pipeline word types and the fixed constants of the fade curve.
// ----------------------------------------------------------------------------
package cvf_pkg;

    localparam int LevelScale = 9600;
    localparam int SliderMax  = 9;

    typedef enum logic [1:0] {
        PH_NONE = 2'd0,
        PH_OUT  = 2'd1,
        PH_IN   = 2'd2,
        PH_ALT  = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        CH_MUSIC = 2'd0,
        CH_FXA   = 2'd1,
        CH_FXB   = 2'd2,
        CH_NONE  = 2'd3
    } chan_t;

    typedef enum logic [1:0] {
        RG_MUSIC   = 2'd0,
        RG_FXA     = 2'd1,
        RG_FXB     = 2'd2,
        RG_SILENCE = 2'd3
    } reg_idx_t;

    // Kind of result the back end produces for a classified word.
    typedef enum logic [1:0] {
        K_ZERO    = 2'd0,
        K_SILENCE = 2'd1,
        K_SLIDER  = 2'd2,
        K_FADE    = 2'd3
    } kind_t;

endpackage

// ===== sv/cvf_front.sv =====
// ----------------------------------------------------------------------------
// cvf_front: request classifier
// Picks the slider, clamps progress and selects the fade numerator.
// ----------------------------------------------------------------------------
module cvf_front import cvf_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic [1:0]  channel,
    input  logic [1:0]  phase,
    input  logic [15:0] progress,
    input  logic [15:0] duration,
    input  logic [3:0]  sld_music,
    input  logic [3:0]  sld_fxa,
    input  logic [3:0]  sld_fxb,
    output kind_t       kind,
    output logic [3:0]  slider,
    output logic [15:0] numer,
    output logic [15:0] denom
);
    logic [15:0] p_clamp;

    always_comb
    begin
        p_clamp = (progress > duration) ? duration : progress;
        numer   = (phase == PH_OUT) ? p_clamp : duration - p_clamp;
        denom   = duration;
        case (channel)
            CH_MUSIC: slider = sld_music;
            CH_FXA:   slider = sld_fxa;
            default:  slider = sld_fxb;
        endcase
        if (channel == CH_NONE)
            kind = K_ZERO;
        else if (phase == PH_NONE || duration == 16'd0)
            kind = (slider == 4'd0) ? K_SILENCE : K_SLIDER;
        else
            kind = K_FADE;
    end

`ifndef NO_ASSERTIONS
    a_numer_le: assert property (@(posedge clk) disable iff (!rst_n)
        numer <= denom) else $error("fade numerator above duration");
`endif
endmodule

// ===== sv/cvf_back.sv =====
// ----------------------------------------------------------------------------
// cvf_back: fade curve pipeline, one word a cycle while advance is high
// Divides, reads the cosine table, interpolates and scales.
// ----------------------------------------------------------------------------
module cvf_back import cvf_pkg::*; #(
    parameter int TabEntries = 256,
    parameter int FracBits   = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  kind_t              in_kind,
    input  logic [3:0]         in_slider,
    input  logic [15:0]        in_numer,
    input  logic [15:0]        in_denom,
    input  logic signed [15:0] silence,
    input  logic               advance,
    output logic               out_valid,
    output logic signed [15:0] out_level
);
    localparam int IdxW  = $clog2(TabEntries);
    localparam int QW    = 17 + IdxW;           // quotient width
    localparam int DW    = 16 + IdxW + 16;      // dividend width
    localparam int NS    = QW;                  // one quotient bit per stage
    localparam int CW    = FracBits + 1;

    typedef logic [TabEntries:0][CW-1:0] tab_t;
    typedef logic [9:0][CW-1:0]          scos_t;

    // Integer Taylor series for cos in Q30, angle in Q30 up to pi/2.
    function automatic longint unsigned cos_q30(input longint unsigned theta);
        longint unsigned t2;
        longint unsigned term;
        longint          sum;
        begin
            t2   = (theta * theta) >> 30;
            term = 64'd1073741824;
            sum  = 64'sd1073741824;
            for (int i = 1; i <= 10; i++)
            begin
                term = ((term * t2) >> 30) / 64'((2 * i - 1) * (2 * i));
                if (i[0])
                    sum -= longint'(term);
                else
                    sum += longint'(term);
            end
            if (sum < 0)
                sum = 0;
            return longint'(sum);
        end
    endfunction

    // Round Q30 half up into Q1.FracBits.
    function automatic logic [CW-1:0] to_frac(input longint unsigned v);
        return CW'((v + (64'd1 << (29 - FracBits))) >> (30 - FracBits));
    endfunction

    function automatic tab_t build_tab();
        tab_t t;
        begin
            for (int k = 0; k <= TabEntries; k++)
                t[k] = to_frac(cos_q30(64'(k) * 64'd1686629713 / 64'(TabEntries)));
            return t;
        end
    endfunction

    // Slider cosine at angle (9-s)*0.4pi/9, for s = 0..9.
    function automatic scos_t build_scos();
        scos_t t;
        begin
            for (int s = 0; s <= 9; s++)
                t[s] = to_frac(cos_q30(64'(9 - s) * 64'd1349303808 / 64'd9));
            return t;
        end
    endfunction

    localparam tab_t  CosTab = build_tab();
    localparam scos_t SldCos = build_scos();

    typedef struct packed {
        logic               v;
        kind_t              kind;
        logic [3:0]         slider;
        logic [DW-1:0]      rem;
        logic [15:0]        den;
        logic [QW-1:0]      quo;
    } dstage_t;

    dstage_t            st_in;
    logic signed [15:0] sil_in;
    dstage_t            st_reg [1:NS];
    logic signed [15:0] sil_reg [1:NS];

    always_comb
    begin
        st_in.v      = in_valid;
        st_in.kind   = in_kind;
        st_in.slider = in_slider;
        st_in.rem    = {in_numer, (DW-16)'(0)};
        st_in.den    = in_denom;
        st_in.quo    = '0;
        sil_in       = silence;
    end

    // Restoring divider, one quotient bit per stage.
    genvar g;
    generate
        for (g = 0; g < NS; g++)
        begin : g_div
            localparam int Sh = NS - 1 - g;
            dstage_t            src;
            logic signed [15:0] sil_src;
            logic [DW+QW-1:0]   dshift;
            logic               ge;
            if (g == 0)
            begin : g_first
                assign src     = st_in;
                assign sil_src = sil_in;
            end
            else
            begin : g_next
                assign src     = st_reg[g];
                assign sil_src = sil_reg[g];
            end
            assign dshift = {{QW{1'b0}}, src.den} << Sh;
            assign ge = {{QW{1'b0}}, src.rem} >= dshift && src.kind == K_FADE;
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    st_reg[g+1]  <= '0;
                    sil_reg[g+1] <= '0;
                end
                else if (advance)
                begin
                    st_reg[g+1].v      <= src.v;
                    st_reg[g+1].kind   <= src.kind;
                    st_reg[g+1].slider <= src.slider;
                    st_reg[g+1].den    <= src.den;
                    st_reg[g+1].rem    <= ge ? DW'({{QW{1'b0}}, src.rem} - dshift)
                                             : src.rem;
                    st_reg[g+1].quo    <= {src.quo[QW-2:0], ge};
                    sil_reg[g+1]       <= sil_src;
                end
            end
        end
    endgenerate

    // Table lookup and interpolation.
    logic               t_v_reg, m_v_reg;
    kind_t              t_kind_reg, m_kind_reg;
    logic [3:0]         t_sld_reg;
    logic signed [15:0] t_sil_reg, m_sil_reg;
    logic [CW-1:0]      t_cf_reg;
    logic [2*CW-1:0]    m_prod_reg;
    logic [QW-1:0]      pos;
    logic [IdxW:0]      idx, idx_n;
    logic [15:0]        frac;
    logic [CW-1:0]      ta, tb, diff, cf;
    logic [CW+15:0]     dprod;

    assign pos  = st_reg[NS].quo;
    assign idx  = pos[QW-1:16] >= (QW-16)'(TabEntries) ? (IdxW+1)'(TabEntries)
                                                        : pos[16+IdxW:16];
    assign frac = pos[15:0];

    always_comb
    begin
        idx_n = (idx == (IdxW+1)'(TabEntries)) ? idx : idx + 1'b1;
        ta    = CosTab[idx];
        tb    = CosTab[idx_n];
        diff  = (ta > tb) ? ta - tb : '0;
        dprod = diff * frac;
        cf    = (idx == (IdxW+1)'(TabEntries)) ? ta : ta - CW'(dprod >> 16);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t_v_reg <= 1'b0;
            m_v_reg <= 1'b0;
            out_valid <= 1'b0;
            t_kind_reg <= K_ZERO;
            m_kind_reg <= K_ZERO;
        end
        else if (advance)
        begin
            t_v_reg <= st_reg[NS].v;
            m_v_reg <= t_v_reg;
            out_valid <= m_v_reg;
            t_kind_reg <= st_reg[NS].kind;
            m_kind_reg <= t_kind_reg;
        end
    end

    logic [2*CW+13:0] scaled;
    logic [CW-1:0]    scos;

    assign scos    = SldCos[t_sld_reg];
    assign scaled  = m_prod_reg * 14'(LevelScale);

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            t_sld_reg  <= st_reg[NS].slider;
            t_sil_reg  <= sil_reg[NS];
            t_cf_reg   <= cf;
            m_sil_reg  <= t_sil_reg;
            m_prod_reg <= (t_kind_reg == K_FADE) ? (2*CW)'(t_cf_reg) * (2*CW)'(scos)
                                                 : (2*CW)'(scos);
            unique case (m_kind_reg)
                K_ZERO:    out_level <= '0;
                K_SILENCE: out_level <= m_sil_reg;
                K_SLIDER:  out_level <= 16'(((scaled + (2*CW+14)'((64'd1 << FracBits) - 1))
                                            >> FracBits) - (2*CW+14)'(LevelScale));
                default:   out_level <= 16'(((scaled + (2*CW+14)'((64'd1 << (2*FracBits)) - 1))
                                            >> (2*FracBits)) - (2*CW+14)'(LevelScale));
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    a_nonpos: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && $past(m_kind_reg) != K_SILENCE |-> out_level <= 0)
        else $error("level above zero");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(out_valid)) else $error("valid moved during stall");
`endif
endmodule

// ===== sv/cosine_volume_fade.sv =====
// ----------------------------------------------------------------------------
// cosine_volume_fade: cosine volume fade curve in centibels
// Turns fade requests into channel volume levels.
// ----------------------------------------------------------------------------
// One word in, one level out. A word is accepted every cycle while the output
// is not stalled. An accepted word is written into the queue, then passes
// the divider (17 + log2(COS_TABLE_ENTRIES) stages, one quotient bit each)
// and three stages of table read, product and scale before out_valid rises.
// The front classifier feeds a two-entry queue; the back pipeline
// advances whenever its output is free or taken, and the queue absorbs the
// stall lag so in_stall depends only on a register. Sliders saturate to 9
// on write and positive silence writes clamp to 0.
module cosine_volume_fade import cvf_pkg::*; #(
    parameter int COS_TABLE_ENTRIES = 256,
    parameter int FRACTION_BITS     = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         channel,
    input  logic [1:0]         phase,
    input  logic [15:0]        progress,
    input  logic [15:0]        duration,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [15:0] level_centibel,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    logic [3:0]         sld_music_reg, sld_fxa_reg, sld_fxb_reg, wsat;
    logic signed [15:0] silence_reg;
    logic               wr;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite;
    assign wsat   = (pwdata[3:0] > 4'(SliderMax)) ? 4'(SliderMax) : pwdata[3:0];

    // Register file: saturate sliders, clamp silence to nonpositive.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sld_music_reg <= 4'd9;
            sld_fxa_reg   <= 4'd9;
            sld_fxb_reg   <= 4'd9;
            silence_reg   <= -16'sd10000;
        end
        else if (wr && paddr[1:0] == 2'b00)
        begin
            case (reg_idx_t'(paddr[3:2]))
                RG_MUSIC: sld_music_reg <= wsat;
                RG_FXA:   sld_fxa_reg   <= wsat;
                RG_FXB:   sld_fxb_reg   <= wsat;
                default:  silence_reg   <= pwdata[15] ? pwdata[15:0] : 16'sd0;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx_t'(paddr[3:2]))
            RG_MUSIC: prdata = {28'd0, sld_music_reg};
            RG_FXA:   prdata = {28'd0, sld_fxa_reg};
            RG_FXB:   prdata = {28'd0, sld_fxb_reg};
            default:  prdata = {{16{silence_reg[15]}}, silence_reg};
        endcase
    end

    // Front classification.
    kind_t       f_kind;
    logic [3:0]  f_slider;
    logic [15:0] f_numer, f_denom;

    cvf_front u_front (
        .clk(clk), .rst_n(rst_n),
        .channel(channel), .phase(phase), .progress(progress), .duration(duration),
        .sld_music(sld_music_reg), .sld_fxa(sld_fxa_reg), .sld_fxb(sld_fxb_reg),
        .kind(f_kind), .slider(f_slider), .numer(f_numer), .denom(f_denom)
    );

    // Word queue between front and back.
    typedef struct packed {
        kind_t       kind;
        logic [3:0]  slider;
        logic [15:0] numer;
        logic [15:0] denom;
    } qword_t;

    qword_t      q_mem_reg [2];
    logic        q_wp_reg, q_rp_reg;
    logic [1:0]  q_cnt_reg;
    logic        push, pop, advance, b_out_valid;

    assign in_stall = q_cnt_reg == 2'd2;
    assign push     = in_valid && !in_stall;
    assign advance  = !(b_out_valid && out_stall);
    assign pop      = advance && q_cnt_reg != 2'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_wp_reg  <= 1'b0;
            q_rp_reg  <= 1'b0;
            q_cnt_reg <= 2'd0;
        end
        else
        begin
            if (push)
                q_wp_reg <= ~q_wp_reg;
            if (pop)
                q_rp_reg <= ~q_rp_reg;
            q_cnt_reg <= q_cnt_reg + 2'(push) - 2'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            q_mem_reg[q_wp_reg] <= '{f_kind, f_slider, f_numer, f_denom};
    end

    qword_t hd;
    assign hd = q_mem_reg[q_rp_reg];

    cvf_back #(.TabEntries(COS_TABLE_ENTRIES), .FracBits(FRACTION_BITS)) u_back (
        .clk(clk), .rst_n(rst_n),
        .in_valid(pop), .in_kind(hd.kind), .in_slider(hd.slider),
        .in_numer(hd.numer), .in_denom(hd.denom), .silence(silence_reg),
        .advance(advance), .out_valid(b_out_valid), .out_level(level_centibel)
    );

    assign out_valid = b_out_valid;

`ifndef NO_ASSERTIONS
    a_q_bound: assert property (@(posedge clk) disable iff (!rst_n)
        q_cnt_reg <= 2'd2) else $error("queue overflow");
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        q_cnt_reg == 2'd2 |-> !push) else $error("push into full queue");
    a_pop_data: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> q_cnt_reg != 2'd0) else $error("pop from empty queue");
`endif
endmodule
